>>> sv/plst_pkg.sv
// ----------------------------------------------------------------------------
// plst_pkg
// shared types, widths and codes of the positional list store
// ----------------------------------------------------------------------------
package plst_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 2;
    localparam int POS_W    = 7;
    localparam int STAT_W   = 2;
    localparam int LEN_W    = 7;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd3;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef logic [DATA_W-1:0] t_word;

    typedef struct packed {
        logic             shift_up;
        logic             shift_down;
        logic             wr;
        logic [CMP_W-1:0] pos;
        t_word            val;
        logic [IDX_W-1:0] last;
    } t_cell_cmd;

    typedef struct packed {
        t_word head;
        t_word rd;
        t_word tail;
    } t_cell_sum;

endpackage

>>> sv/plst_if.sv
// ----------------------------------------------------------------------------
// plst_if
// valid/ready channels carrying request and result words
// ----------------------------------------------------------------------------
interface plst_in_if;
    import plst_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [POS_W-1:0]  position;
    logic signed [DATA_W-1:0] write_value;

    modport source (output valid, output operation, output position,
                    output write_value, input ready);
    modport sink   (input valid, input operation, input position,
                    input write_value, output ready);
endinterface

interface plst_out_if;
    import plst_pkg::*;

    logic              valid;
    logic              ready;
    logic signed [DATA_W-1:0] read_value;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  length;
    logic              is_empty;
    logic signed [DATA_W-1:0] first_value;
    logic signed [DATA_W-1:0] last_value;

    modport source (output valid, output read_value, output status, output length,
                    output is_empty, output first_value, output last_value,
                    input ready);
    modport sink   (input valid, input read_value, input status, input length,
                    input is_empty, input first_value, input last_value,
                    output ready);
endinterface

>>> sv/plst_cell.sv
// ----------------------------------------------------------------------------
// plst_cell
// one list entry: shifts with its neighbours, takes writes, offers read taps
// ----------------------------------------------------------------------------
module plst_cell
    import plst_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_cmd        i_cmd,
    input  logic [IDX_W-1:0] i_index,
    input  t_word            i_lo,
    input  t_word            i_hi,
    output t_word            o_data,
    output t_word            o_rd,
    output t_word            o_tail
);

    t_word            r_data;
    t_word            n_data;
    logic [CMP_W-1:0] w_idx;
    logic             w_match;
    logic             w_above;

    assign w_idx   = CMP_W'(i_index);
    assign w_match = (w_idx == i_cmd.pos);
    assign w_above = (w_idx > i_cmd.pos);

    always_comb begin
        n_data = r_data;
        if (i_cmd.shift_up) begin
            if (w_above) begin
                n_data = i_lo;
            end else if (w_match) begin
                n_data = i_cmd.val;
            end
        end else if (i_cmd.shift_down) begin
            if (w_above || w_match) begin
                n_data = i_hi;
            end
        end else if (i_cmd.wr && w_match) begin
            n_data = i_cmd.val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_rd   = w_match ? r_data : '0;
    assign o_tail = (i_index == i_cmd.last) ? r_data : '0;

endmodule

>>> sv/plst_ctrl.sv
// ----------------------------------------------------------------------------
// plst_ctrl
// request decode, entry count and result word sequencing
// ----------------------------------------------------------------------------
module plst_ctrl
    import plst_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    plst_in_if.sink        i_in,
    plst_out_if.source     o_out,
    input  t_cell_sum      i_sum,
    output t_cell_cmd      o_cmd
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_EXEC = 2'd1;
    localparam logic [1:0] PH_REP  = 2'd2;

    logic [1:0]        r_phase;
    logic              r_out_v;
    logic [OP_W-1:0]   r_op;
    logic [CMP_W-1:0]  r_pos;
    t_word             r_val;
    logic [CNT_W-1:0]  r_count;
    logic [STAT_W-1:0] r_status;
    t_word             r_rd;

    logic [STAT_W-1:0] r_o_status;
    logic [LEN_W-1:0]  r_o_len;
    logic              r_o_empty;
    t_word             r_o_rd;
    t_word             r_o_first;
    t_word             r_o_last;

    logic              w_accept;
    logic              w_exec;
    logic              w_ok;
    logic [STAT_W-1:0] w_status;
    logic [CMP_W-1:0]  w_n;
    logic              w_out_free;

    assign i_in.ready = (r_phase == PH_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_exec     = (r_phase == PH_EXEC);
    assign w_n        = CMP_W'(r_count);
    assign w_out_free = !r_out_v || o_out.ready;

    always_comb begin
        w_status = ST_DONE;
        if (r_op == OP_INSERT) begin
            if (r_pos > w_n) begin
                w_status = ST_RANGE;
            end else if (r_count >= CNT_W'(CAPACITY)) begin
                w_status = ST_FULL;
            end
        end else if (r_pos >= w_n) begin
            w_status = ST_RANGE;
        end
    end

    assign w_ok = (w_status == ST_DONE);

    always_comb begin
        o_cmd.shift_up   = w_exec && w_ok && (r_op == OP_INSERT);
        o_cmd.shift_down = w_exec && w_ok && (r_op == OP_REMOVE);
        o_cmd.wr         = w_exec && w_ok && (r_op == OP_WRITE);
        o_cmd.pos        = r_pos;
        o_cmd.val        = r_val;
        o_cmd.last       = IDX_W'(r_count - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_out_v <= 1'b0;
            r_count <= '0;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (w_accept) begin
                        r_phase <= PH_EXEC;
                    end
                end
                PH_EXEC: begin
                    if (w_ok && (r_op == OP_INSERT)) begin
                        r_count <= r_count + 1'b1;
                    end else if (w_ok && (r_op == OP_REMOVE)) begin
                        r_count <= r_count - 1'b1;
                    end
                    r_phase <= PH_REP;
                end
                PH_REP: begin
                    if (w_out_free) begin
                        r_phase <= PH_IDLE;
                    end
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
            if ((r_phase == PH_REP) && w_out_free) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_in.operation;
            r_pos <= CMP_W'(i_in.position);
            r_val <= i_in.write_value;
        end
        if (w_exec) begin
            r_status <= w_status;
            r_rd     <= (w_ok && (r_op == OP_READ)) ? i_sum.rd : '0;
        end
        if ((r_phase == PH_REP) && w_out_free) begin
            r_o_status <= r_status;
            r_o_len    <= LEN_W'(r_count);
            r_o_empty  <= (r_count == '0);
            r_o_rd     <= r_rd;
            r_o_first  <= (r_count != '0) ? i_sum.head : '0;
            r_o_last   <= (r_count != '0) ? i_sum.tail : '0;
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.read_value  = r_o_rd;
    assign o_out.status      = r_o_status;
    assign o_out.length      = r_o_len;
    assign o_out.is_empty    = r_o_empty;
    assign o_out.first_value = r_o_first;
    assign o_out.last_value  = r_o_last;

endmodule

>>> sv/positional_list_store_top.sv
// ----------------------------------------------------------------------------
// positional_list_store_top
// bounded ordered list held in a row of shifting entry cells
// ----------------------------------------------------------------------------
//  channel   dir   handshake      word
//  i_in      in    valid/ready    operation, position, write_value
//  o_out     out   valid/ready    read_value, status, length, is_empty,
//                                 first_value, last_value
//
//  an accepted word reaches o_out in steps: the request is registered, then all
//  cells shift or write at once, then the head and tail taps are gathered into
//  the result registers; no new word is taken until that result is gathered
//  i_rst_n clears the entry count and the sequencer; entries need no reset
//  a stalled o_out holds the gather step and so i_in.ready
// ----------------------------------------------------------------------------
module positional_list_store_top
    import plst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    plst_in_if.sink    i_in,
    plst_out_if.source o_out
);

    t_cell_cmd w_cmd;
    t_cell_sum w_sum;
    t_word     w_data [CAPACITY];
    t_word     w_rd   [CAPACITY];
    t_word     w_tail [CAPACITY];
    logic [DATA_W-1:0][CAPACITY-1:0] w_rd_col;
    logic [DATA_W-1:0][CAPACITY-1:0] w_tail_col;

    plst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_sum   (w_sum),
        .o_cmd   (w_cmd)
    );

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        t_word w_lo;
        t_word w_hi;
        if (k == 0) begin : g_lo0
            assign w_lo = '0;
        end else begin : g_lon
            assign w_lo = w_data[k-1];
        end
        if (k == CAPACITY - 1) begin : g_hi0
            assign w_hi = '0;
        end else begin : g_hin
            assign w_hi = w_data[k+1];
        end
        plst_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_index (IDX_W'(k)),
            .i_lo    (w_lo),
            .i_hi    (w_hi),
            .o_data  (w_data[k]),
            .o_rd    (w_rd[k]),
            .o_tail  (w_tail[k])
        );
        for (genvar b = 0; b < DATA_W; b++) begin : g_bit
            assign w_rd_col[b][k]   = w_rd[k][b];
            assign w_tail_col[b][k] = w_tail[k][b];
        end
    end

    for (genvar b = 0; b < DATA_W; b++) begin : g_or
        assign w_sum.rd[b]   = |w_rd_col[b];
        assign w_sum.tail[b] = |w_tail_col[b];
    end

    assign w_sum.head = w_data[0];

`ifndef SYNTHESIS
    a_empty_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.is_empty == (o_out.length == '0)))
        else $error("empty flag disagrees with length");

    a_len_cap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.length <= LEN_W'(CAPACITY)))
        else $error("length beyond capacity");

    a_full_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == ST_FULL)) |-> (o_out.length == LEN_W'(CAPACITY)))
        else $error("full status with spare room");

    a_empty_vals : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.is_empty) |->
            ((o_out.first_value == '0) && (o_out.last_value == '0)))
        else $error("empty list reports head or tail");
`endif

endmodule

>>> tb/positional_list_store_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_store_top_tb
// self-checking bench for the positional list store: request words are
// driven with random gaps, results are taken with random stalls, and each
// result word is checked against a behavioural copy of the list
// ----------------------------------------------------------------------------
module positional_list_store_top_tb;
    import plst_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_TAIL  = 8;

    typedef struct {
        logic signed [DATA_W-1:0] read_value;
        logic [STAT_W-1:0]        status;
        logic [LEN_W-1:0]         length;
        logic                     is_empty;
        logic signed [DATA_W-1:0] first_value;
        logic signed [DATA_W-1:0] last_value;
    } t_list_result;

    logic i_clk;
    logic i_rst_n;

    plst_in_if  in_ch ();
    plst_out_if out_ch ();

    positional_list_store_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // behavioural copy of the list
    logic signed [DATA_W-1:0] list_mem [CAPACITY];
    int                       list_len;

    t_list_result pending_results [$];
    int           error_count;
    int           idle_cycles;
    int           op_seen [4];
    int           status_seen [3];
    int           peak_len;
    bit           calm_stretch;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_list_result apply_list_op(logic [OP_W-1:0] op,
                                                   logic [POS_W-1:0] pos,
                                                   logic signed [DATA_W-1:0] val);
        t_list_result r;
        int           p;
        p = int'(pos);
        r.read_value = '0;
        r.status     = ST_DONE;
        if (op == OP_INSERT) begin
            if (p > list_len) begin
                r.status = ST_RANGE;
            end else if (list_len >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                for (int i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
                list_mem[p] = val;
                list_len++;
            end
        end else if (p >= list_len) begin
            r.status = ST_RANGE;
        end else if (op == OP_REMOVE) begin
            for (int i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
            list_len--;
        end else if (op == OP_READ) begin
            r.read_value = list_mem[p];
        end else begin
            list_mem[p] = val;
        end
        r.length      = LEN_W'(list_len);
        r.is_empty    = (list_len == 0);
        r.first_value = (list_len > 0) ? list_mem[0] : '0;
        r.last_value  = (list_len > 0) ? list_mem[list_len-1] : '0;
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99, 0);
        if (calm_stretch || roll < 60) return 0;
        if (roll < 90) return $urandom_range(3, 1);
        if (roll < 98) return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(19, 0))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_pos(logic [OP_W-1:0] op);
        bit bad;
        bad = ($urandom_range(99, 0) < 15);
        if (op == OP_INSERT) begin
            if (bad && list_len < CAPACITY)
                return POS_W'($urandom_range(CAPACITY, list_len + 1));
            return POS_W'($urandom_range(list_len, 0));
        end
        if (list_len == 0) return POS_W'($urandom_range(CAPACITY, 0));
        if (bad) return POS_W'($urandom_range(CAPACITY, list_len));
        return POS_W'($urandom_range(list_len - 1, 0));
    endfunction

    task automatic send_word(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                             logic signed [DATA_W-1:0] val);
        int gap;
        in_ch.valid       = 1'b1;
        in_ch.operation   = op;
        in_ch.position    = pos;
        in_ch.write_value = val;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) begin
                in_ch.operation   = OP_W'($urandom);
                in_ch.position    = POS_W'($urandom);
                in_ch.write_value = $urandom;
                @(negedge i_clk);
            end
        end
    endtask

    task automatic random_word(int ins_pct, int rem_pct, int rd_pct);
        int               roll;
        logic [OP_W-1:0]  op;
        roll = $urandom_range(99, 0);
        if (roll < ins_pct)                         op = OP_INSERT;
        else if (roll < ins_pct + rem_pct)          op = OP_REMOVE;
        else if (roll < ins_pct + rem_pct + rd_pct) op = OP_READ;
        else                                        op = OP_WRITE;
        send_word(op, pick_pos(op), pick_value());
    endtask

    task automatic test_empty_list();
        send_word(OP_REMOVE, 0, 32'sd5);
        send_word(OP_READ, 0, 32'sd0);
        send_word(OP_WRITE, 0, 32'sh1234_5678);
        send_word(OP_READ, 7'd64, 32'sd0);
        send_word(OP_INSERT, 1, 32'sd9);
        send_word(OP_INSERT, 7'd64, 32'sd9);
    endtask

    task automatic test_edge_values();
        send_word(OP_INSERT, 0, 32'sh7FFF_FFFF);
        send_word(OP_INSERT, 1, 32'sh8000_0000);
        send_word(OP_INSERT, 0, -32'sd1);
        send_word(OP_INSERT, 1, 32'sd0);
        send_word(OP_READ, 0, 32'sh7FFF_FFFF);
        send_word(OP_READ, 3, 32'sd0);
        send_word(OP_READ, 4, 32'sd0);
        send_word(OP_WRITE, 3, 32'sh5555_5555);
        send_word(OP_WRITE, 0, 32'shAAAA_AAAA);
        send_word(OP_INSERT, 5, 32'sd1);
        send_word(OP_REMOVE, 3, 32'sd0);
        send_word(OP_REMOVE, 0, 32'sd0);
        send_word(OP_REMOVE, 1, 32'sd0);
        send_word(OP_READ, 0, 32'sd0);
        send_word(OP_REMOVE, 0, 32'sd0);
        send_word(OP_REMOVE, 0, 32'sd0);
    endtask

    task automatic test_fill_to_capacity();
        while (list_len < CAPACITY)
            send_word(OP_INSERT, POS_W'($urandom_range(list_len, 0)), pick_value());
        send_word(OP_INSERT, 7'd64, pick_value());
        send_word(OP_INSERT, 0, pick_value());
        send_word(OP_READ, 7'd63, 32'sd0);
        send_word(OP_READ, 7'd64, 32'sd0);
        repeat (4) send_word(OP_INSERT, POS_W'($urandom_range(CAPACITY, 0)), pick_value());
    endtask

    task automatic test_random_mix();
        repeat (120) random_word(30, 35, 15);
        repeat (100) random_word(60, 15, 10);
        repeat (110) random_word(35, 35, 15);
        repeat (100) random_word(25, 25, 25);
    endtask

    task automatic test_drain_to_empty();
        while (list_len > 0)
            send_word(OP_REMOVE, POS_W'($urandom_range(list_len - 1, 0)), pick_value());
        send_word(OP_REMOVE, 0, 32'sd0);
        send_word(OP_READ, 0, 32'sd0);
    endtask

    // result side: random stalls with calm stretches
    initial begin
        int stall_left;
        int roll;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left--;
            end else begin
                out_ch.ready = 1'b1;
                roll = $urandom_range(99, 0);
                if (!calm_stretch && roll < 25) begin
                    if (roll < 2) stall_left = $urandom_range(40, 20);
                    else if (roll < 6) stall_left = $urandom_range(10, 4);
                    else stall_left = $urandom_range(3, 1);
                end
            end
        end
    end

    initial begin
        calm_stretch = 1'b0;
        forever begin
            repeat ($urandom_range(300, 100)) @(posedge i_clk);
            calm_stretch = ($urandom_range(3, 0) == 0);
        end
    end

    // acceptance monitor and checker
    always @(posedge i_clk) begin
        t_list_result exp_r;
        bit           moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (out_ch.valid === 1'b1 && out_ch.ready) begin
                moved = 1'b1;
                if (pending_results.size() == 0) begin
                    $error("result word with no request outstanding");
                    error_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (out_ch.read_value !== exp_r.read_value) begin
                        $error("read_value expected %0d got %0d",
                               exp_r.read_value, out_ch.read_value);
                        error_count++;
                    end
                    if (out_ch.status !== exp_r.status) begin
                        $error("status expected %0d got %0d", exp_r.status, out_ch.status);
                        error_count++;
                    end
                    if (out_ch.length !== exp_r.length) begin
                        $error("length expected %0d got %0d", exp_r.length, out_ch.length);
                        error_count++;
                    end
                    if (out_ch.is_empty !== exp_r.is_empty) begin
                        $error("is_empty expected %0d got %0d",
                               exp_r.is_empty, out_ch.is_empty);
                        error_count++;
                    end
                    if (out_ch.first_value !== exp_r.first_value) begin
                        $error("first_value expected %0d got %0d",
                               exp_r.first_value, out_ch.first_value);
                        error_count++;
                    end
                    if (out_ch.last_value !== exp_r.last_value) begin
                        $error("last_value expected %0d got %0d",
                               exp_r.last_value, out_ch.last_value);
                        error_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready === 1'b1) begin
                moved = 1'b1;
                exp_r = apply_list_op(in_ch.operation, in_ch.position, in_ch.write_value);
                pending_results.push_back(exp_r);
                op_seen[in_ch.operation]++;
                status_seen[exp_r.status]++;
                if (list_len > peak_len) peak_len = list_len;
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("positional_list_store_top_tb: errors");
            $finish;
        end
    end

    initial begin
        error_count       = 0;
        idle_cycles       = 0;
        list_len          = 0;
        peak_len          = 0;
        op_seen           = '{default: 0};
        status_seen       = '{default: 0};
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.operation   = OP_INSERT;
        in_ch.position    = '0;
        in_ch.write_value = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_list();
        test_edge_values();
        test_fill_to_capacity();
        test_random_mix();
        test_drain_to_empty();
        in_ch.valid = 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);

        $display("requests: %0d insert, %0d remove, %0d read, %0d overwrite; peak length %0d",
                 op_seen[OP_INSERT], op_seen[OP_REMOVE], op_seen[OP_READ],
                 op_seen[OP_WRITE], peak_len);
        $display("outcomes: %0d done, %0d out of range or empty, %0d full",
                 status_seen[ST_DONE], status_seen[ST_RANGE], status_seen[ST_FULL]);
        if (error_count == 0) begin
            $display("positional_list_store_top_tb: clean");
        end else begin
            $display("positional_list_store_top_tb: errors");
        end
        $finish;
    end

endmodule

>>> positional_list_store_top.f
sv/plst_pkg.sv
sv/plst_if.sv
sv/plst_cell.sv
sv/plst_ctrl.sv
sv/positional_list_store_top.sv
tb/positional_list_store_top_tb.sv
